/* hdl/lfs_pkg.sv */
// Package for the LED fade sequencer: item types, table entry layout and sizing constants.
// No dependencies; the core and the checker refer to it by scoped names.
`default_nettype none

package lfs_pkg;

  // Step table sizing.
  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int PosW       = $clog2(TableDepth + 1);

  // Field widths fixed by the item formats.
  localparam int CfgW   = 5;
  localparam int PctW   = 7;
  localparam int DurW   = 16;
  localparam int StepW  = 4;
  localparam int DivW   = 5;
  localparam int IterW  = $clog2(DurW);
  localparam int CmpW   = (PosW > CfgW) ? PosW : CfgW;

  // Level limits and fade step size.
  localparam int MaxPct   = 100;
  localparam int FadeStep = 5;

  // span / 5 as (span * 205) >> 10, exact for spans below 256.
  localparam int Div5Mul   = 205;
  localparam int Div5Shift = 10;

  // (level * 255) / 100 as (x * 41944) >> 22, exact for x below 43690.
  localparam int PwmMul   = 41944;
  localparam int PwmShift = 22;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  // One input item.
  typedef struct packed {
    op_e               operation;
    logic [3:0]        entry_index;
    logic              entry_is_fade;
    logic [PctW-1:0]   entry_from;
    logic [PctW-1:0]   entry_to;
    logic [DurW-1:0]   entry_duration;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]        pwm_level;
    logic [PctW-1:0]   level_percent;
    logic              running;
    logic [StepW-1:0]  step_index;
  } out_item_t;

  // One step table entry as stored in the table memory.
  typedef struct packed {
    logic              is_fade;
    logic [PctW-1:0]   from;
    logic [PctW-1:0]   to;
    logic [DurW-1:0]   duration;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/lfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/led_fade_sequencer_core.sv */
// Top level of the LED fade sequencer: control sequencer, step divider and output register.
// Depends on lfs_pkg and on lfs_ram, which holds the step table.
//
//   Channel | Signals                          | Direction | Moves
//   --------+----------------------------------+-----------+---------------------------------
//   cfg     | cfg_valid_i cfg_ready_o cfg_data_i | in      | sequence length write
//   in      | in_valid_i in_ready_o in_data_i  | in        | one item: write/start/tick/nop
//   out     | out_valid_o out_ready_i out_data_o | out     | one result item per input item
//
// An accepted item passes through ST_EXEC, then ST_LOAD when a step loads, then ST_DIV
// when a fade with a nonzero span / 5 loads, where the restoring divider works out
// duration / (span / 5), and last ST_EMIT, which registers the result item. The next
// item is accepted in ST_IDLE, entered from ST_EMIT. One item is in work at a time; a
// finished result waits in the output register while the next item is accepted, and
// only the result stage stalls on out_ready_i.
// Reset clears control state and sets sequence length 1; the step table has no reset value.
`default_nettype none

module led_fade_sequencer_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [4:0]       cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lfs_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lfs_pkg::out_item_t    out_data_o
);

  localparam int IdxW  = lfs_pkg::IdxW;
  localparam int PosW  = lfs_pkg::PosW;
  localparam int CmpW  = lfs_pkg::CmpW;
  localparam int PctW  = lfs_pkg::PctW;
  localparam int DurW  = lfs_pkg::DurW;
  localparam int DivW  = lfs_pkg::DivW;
  localparam int IterW = lfs_pkg::IterW;
  localparam int StepW = lfs_pkg::StepW;
  localparam int CfgW  = lfs_pkg::CfgW;

  // Registers.
  lfs_pkg::state_e    state_q, state_d;
  lfs_pkg::in_item_t  item_q, item_d;
  logic [CfgW-1:0]    seq_len_q, seq_len_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PctW-1:0]    cur_q, cur_d;
  logic [PctW-1:0]    tgt_q, tgt_d;
  logic               fading_q, fading_d;
  logic               rising_q, rising_d;
  logic [DurW-1:0]    interval_q, interval_d;
  logic [DurW-1:0]    count_q, count_d;
  logic               active_q, active_d;
  logic [DivW-1:0]    div_q, div_d;
  logic [DurW-1:0]    dvd_q, dvd_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic               out_valid_q, out_valid_d;
  lfs_pkg::out_item_t out_q, out_d;

  // Control outputs of the sequencer.
  logic               ram_we;
  logic               ram_re;
  logic               emit_fire;

  // Decisions for the next-state, sequencer output and datapath logic.
  logic               exec_load;
  logic               load_div;
  logic               div_last;

  // Table memory signals.
  lfs_pkg::entry_t    wr_entry;
  lfs_pkg::entry_t    rd_entry;
  logic [IdxW-1:0]    ram_waddr;
  logic [IdxW-1:0]    ram_raddr;
  logic [IdxW+3:0]    widx_ext;
  logic               widx_ok;

  // Helpers.
  logic [CmpW-1:0]    eff_len;
  logic [PosW-1:0]    pos_next;
  logic [DurW-1:0]    cnt_dec;
  logic               can_move;
  logic [PctW:0]      cur_up;
  logic [PctW-1:0]    cur_step;
  logic [DurW-1:0]    ld_dur;
  logic [PctW-1:0]    ld_span;
  logic [14:0]        ld_prod;
  logic [DivW-1:0]    ld_div5;
  logic [DivW:0]      div_trial;
  logic               div_bit;
  logic [DurW-1:0]    div_quot;
  logic [14:0]        pwm_x;
  logic [31:0]        pwm_prod;
  logic [PosW+3:0]    pos_ext;

  // Configuration port is always ready; the user must write only while idle; not enforced.
  assign cfg_ready_o = 1'b1;
  assign seq_len_d   = cfg_valid_i ? cfg_data_i : seq_len_q;

  // Effective length saturates at the table depth.
  assign eff_len = (CmpW'(seq_len_q) > CmpW'(lfs_pkg::TableDepth))
                 ? CmpW'(lfs_pkg::TableDepth) : CmpW'(seq_len_q);

  // Write address and range check for table writes.
  assign widx_ext  = {{IdxW{1'b0}}, item_q.entry_index};
  assign ram_waddr = widx_ext[IdxW-1:0];
  assign widx_ok   = 32'(item_q.entry_index) < 32'(lfs_pkg::TableDepth);

  // Table entry with levels clamped at full scale.
  always_comb begin
    wr_entry.is_fade  = item_q.entry_is_fade;
    wr_entry.from     = (item_q.entry_from > PctW'(lfs_pkg::MaxPct))
                      ? PctW'(lfs_pkg::MaxPct) : item_q.entry_from;
    wr_entry.to       = (item_q.entry_to > PctW'(lfs_pkg::MaxPct))
                      ? PctW'(lfs_pkg::MaxPct) : item_q.entry_to;
    wr_entry.duration = item_q.entry_duration;
  end

  // Tick arithmetic: countdown, fade move and next position.
  assign cnt_dec  = (count_q != '0) ? count_q - DurW'(1) : count_q;
  assign can_move = fading_q && ((rising_q && (cur_q < tgt_q)) ||
                                 (!rising_q && (cur_q > tgt_q)));
  assign cur_up   = {1'b0, cur_q} + (PctW+1)'(lfs_pkg::FadeStep);
  always_comb begin
    if (rising_q) begin
      cur_step = (cur_up > {1'b0, tgt_q}) ? tgt_q : cur_up[PctW-1:0];
    end else begin
      cur_step = ({1'b0, cur_q} < ({1'b0, tgt_q} + (PctW+1)'(lfs_pkg::FadeStep)))
               ? tgt_q : cur_q - PctW'(lfs_pkg::FadeStep);
    end
  end
  assign pos_next = pos_q + PosW'(1);

  // The read address is the next position on a tick and step zero on a start.
  assign ram_raddr = (item_q.operation == lfs_pkg::OP_START) ? '0 : pos_next[IdxW-1:0];

  // Does this item need a step load?
  always_comb begin
    exec_load = 1'b0;
    case (item_q.operation)
      lfs_pkg::OP_START: exec_load = (eff_len != '0);
      lfs_pkg::OP_TICK:  exec_load = active_q && (cnt_dec == '0) && !can_move &&
                                     (CmpW'(pos_next) < eff_len);
      default:           exec_load = 1'b0;
    endcase
  end

  // Step load arithmetic on the entry read from the table.
  assign ld_dur   = (rd_entry.duration == '0) ? DurW'(1) : rd_entry.duration;
  assign ld_span  = (rd_entry.from < rd_entry.to) ? rd_entry.to - rd_entry.from
                                                  : rd_entry.from - rd_entry.to;
  assign ld_prod  = 15'(ld_span) * 15'(lfs_pkg::Div5Mul);
  assign ld_div5  = ld_prod[lfs_pkg::Div5Shift +: DivW];
  assign load_div = rd_entry.is_fade && (ld_div5 != '0);

  // One restoring division step per cycle.
  assign div_trial = {rem_q, dvd_q[DurW-1]};
  assign div_bit   = (div_trial >= {1'b0, div_q});
  assign div_quot  = {dvd_q[DurW-2:0], div_bit};
  assign div_last  = (iter_q == IterW'(DurW - 1));

  // Result fields: PWM duty by reciprocal multiply.
  assign pwm_x    = {cur_q, 8'b0} - 15'(cur_q);
  assign pwm_prod = 32'(pwm_x) * 32'(lfs_pkg::PwmMul);
  assign pos_ext  = {4'b0, pos_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfs_pkg::ST_IDLE: if (in_valid_i) state_d = lfs_pkg::ST_EXEC;
      lfs_pkg::ST_EXEC: state_d = exec_load ? lfs_pkg::ST_LOAD : lfs_pkg::ST_EMIT;
      lfs_pkg::ST_LOAD: state_d = load_div ? lfs_pkg::ST_DIV : lfs_pkg::ST_EMIT;
      lfs_pkg::ST_DIV:  if (div_last) state_d = lfs_pkg::ST_EMIT;
      lfs_pkg::ST_EMIT: if (!out_valid_q || out_ready_i) state_d = lfs_pkg::ST_IDLE;
      default:          state_d = lfs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    emit_fire  = 1'b0;
    case (state_q)
      lfs_pkg::ST_IDLE: in_ready_o = 1'b1;
      lfs_pkg::ST_EXEC: begin
        ram_we = (item_q.operation == lfs_pkg::OP_WRITE) && widx_ok;
        ram_re = exec_load;
      end
      lfs_pkg::ST_EMIT: emit_fire = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    item_d      = item_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    fading_d    = fading_q;
    rising_d    = rising_q;
    interval_d  = interval_q;
    count_d     = count_q;
    active_d    = active_q;
    div_d       = div_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (in_valid_i && in_ready_o) begin
      item_d = in_data_i;
    end

    case (state_q)
      // Apply start and tick effects; table writes go straight to the memory.
      lfs_pkg::ST_EXEC: begin
        case (item_q.operation)
          lfs_pkg::OP_START: begin
            fading_d = 1'b0;
            pos_d    = '0;
            active_d = (eff_len != '0);
          end
          lfs_pkg::OP_TICK: begin
            if (active_q) begin
              count_d = cnt_dec;
              if (cnt_dec == '0) begin
                if (can_move) begin
                  cur_d   = cur_step;
                  count_d = interval_q;
                end else begin
                  pos_d = pos_next;
                  if (CmpW'(pos_next) >= eff_len) begin
                    active_d = 1'b0;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
      // Load the step that the table read returned.
      lfs_pkg::ST_LOAD: begin
        cur_d = rd_entry.from;
        if (rd_entry.is_fade) begin
          tgt_d    = rd_entry.to;
          fading_d = 1'b1;
          rising_d = rd_entry.from < rd_entry.to;
          if (ld_div5 == '0) begin
            interval_d = ld_dur;
            count_d    = ld_dur;
          end else begin
            dvd_d  = ld_dur;
            div_d  = ld_div5;
            rem_d  = '0;
            iter_d = '0;
          end
        end else begin
          fading_d = 1'b0;
          count_d  = ld_dur;
        end
      end
      // Fade interval: one quotient bit per cycle; an interval of zero becomes one.
      lfs_pkg::ST_DIV: begin
        rem_d  = div_bit ? DivW'(div_trial - {1'b0, div_q}) : div_trial[DivW-1:0];
        dvd_d  = div_quot;
        iter_d = iter_q + IterW'(1);
        if (div_last) begin
          interval_d = (div_quot == '0) ? DurW'(1) : div_quot;
          count_d    = (div_quot == '0) ? DurW'(1) : div_quot;
        end
      end
      // Present the status as a result item.
      lfs_pkg::ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d         = 1'b1;
          out_d.pwm_level     = active_q ? pwm_prod[lfs_pkg::PwmShift +: 8] : 8'd0;
          out_d.level_percent = cur_q;
          out_d.running       = active_q;
          out_d.step_index    = active_q ? pos_ext[StepW-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  // Control and sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfs_pkg::ST_IDLE;
      seq_len_q   <= CfgW'(1);
      pos_q       <= '0;
      cur_q       <= '0;
      tgt_q       <= '0;
      fading_q    <= 1'b0;
      rising_q    <= 1'b0;
      interval_q  <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seq_len_q   <= seq_len_d;
      pos_q       <= pos_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      fading_q    <= fading_d;
      rising_q    <= rising_d;
      interval_q  <= interval_d;
      count_q     <= count_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    div_q  <= div_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    iter_q <= iter_d;
    out_q  <= out_d;
  end

  // Step table memory.
  lfs_ram #(
    .Width ($bits(lfs_pkg::entry_t)),
    .Depth (lfs_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/lfs_checker.sv */
// Port-level checks for the LED fade sequencer, bound to the top level.
// Depends on lfs_pkg and on led_fade_sequencer_core's port list.
`default_nettype none

module lfs_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire lfs_pkg::out_item_t out_data_o
);

  // A stalled result item holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item dropped or changed while stalled");

  // An accepted input item is followed by no new acceptance in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // A stopped sequence shows zero duty and step zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.running |->
      (out_data_o.pwm_level == 8'd0) && (out_data_o.step_index == '0))
    else $error("idle result shows duty or step");

  // Full duty exactly at full level while running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.running |->
      ((out_data_o.level_percent == 7'd100) == (out_data_o.pwm_level == 8'd255)))
    else $error("duty does not match level");

endmodule

bind led_fade_sequencer_core lfs_checker u_lfs_checker (.*);

`default_nettype wire
